FILE: sv/spf_pkg.sv
`default_nettype none

package spf_pkg;

  // Transform length and the widths that follow from it
  localparam int FFT_LEN  = 1024;
  localparam int FFT_LOG2 = $clog2(FFT_LEN);
  localparam int CNT_W    = $clog2(FFT_LEN + 1);
  localparam int IDX_W    = $clog2(FFT_LEN);

  // Bins searched for the peak
  localparam int RANGE_LO = 1;
  localparam int RANGE_HI = FFT_LEN / 2 - 2;

  // Field widths
  localparam int MAG_W       = 32;
  localparam int POW_W       = 64;
  localparam int LVL_W       = 7;
  localparam int PEAK_BIN_W  = 9;
  localparam int FREQ_W      = 19;
  localparam int DIGIT_W     = 4;
  localparam int RATE_W      = 20;
  localparam int RATE_RESET  = 20000;

  // Level search: 94 thresholds, binary search over 7 bits
  localparam int LEVEL_STEPS  = 94;
  localparam int SEARCH_STEPS = $clog2(LEVEL_STEPS + 1);

  // Frequency and digit conversion
  localparam int PROD_W      = IDX_W + RATE_W;
  localparam int FREQ_FULL_W = PROD_W - FFT_LOG2;
  localparam int DIGIT_CAP   = 9999;
  localparam int DIGIT_MAX   = 9;
  localparam int BCD_W       = 14;

  // Stream data layout
  localparam int IN_DATA_W     = 2 * MAG_W;
  localparam int OUT_FIELDS_W  = PEAK_BIN_W + LVL_W + FREQ_W + 4 * DIGIT_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_LVL_LSB   = PEAK_BIN_W;
  localparam int OUT_FREQ_LSB  = OUT_LVL_LSB + LVL_W;
  localparam int OUT_DT_LSB    = OUT_FREQ_LSB + FREQ_W;
  localparam int OUT_DH_LSB    = OUT_DT_LSB + DIGIT_W;
  localparam int OUT_DN_LSB    = OUT_DH_LSB + DIGIT_W;
  localparam int OUT_DU_LSB    = OUT_DN_LSB + DIGIT_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             last;
  } spf_tag_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_re;
    logic [MAG_W-1:0] mag_im;
    spf_tag_t         tag;
  } spf_item_t;

  // Power threshold of each whole-decibel level, ceil((10^(L/10)-1)^2)
  function automatic logic [POW_W-1:0] spf_level_th(input logic [LVL_W-1:0] lvl);
    logic [POW_W-1:0] th;
    unique case (lvl)
      7'd0:  th = 64'd0;
      7'd1:  th = 64'd1;
      7'd2:  th = 64'd1;
      7'd3:  th = 64'd1;
      7'd4:  th = 64'd3;
      7'd5:  th = 64'd5;
      7'd6:  th = 64'd9;
      7'd7:  th = 64'd17;
      7'd8:  th = 64'd29;
      7'd9:  th = 64'd49;
      7'd10: th = 64'd81;
      7'd11: th = 64'd135;
      7'd12: th = 64'd221;
      7'd13: th = 64'd360;
      7'd14: th = 64'd582;
      7'd15: th = 64'd938;
      7'd16: th = 64'd1507;
      7'd17: th = 64'd2413;
      7'd18: th = 64'd3856;
      7'd19: th = 64'd6152;
      7'd20: th = 64'd9801;
      7'd21: th = 64'd15599;
      7'd22: th = 64'd24803;
      7'd23: th = 64'd39413;
      7'd24: th = 64'd62595;
      7'd25: th = 64'd99369;
      7'd26: th = 64'd157695;
      7'd27: th = 64'd250188;
      7'd28: th = 64'd396847;
      7'd29: th = 64'd629370;
      7'd30: th = 64'd998001;
      7'd31: th = 64'd1582377;
      7'd32: th = 64'd2508718;
      7'd33: th = 64'd3977083;
      7'd34: th = 64'd6304551;
      7'd35: th = 64'd9993677;
      7'd36: th = 64'd15840971;
      7'd37: th = 64'd25108842;
      7'd38: th = 64'd39798099;
      7'd39: th = 64'd63079849;
      7'd40: th = 64'd99980001;
      7'd41: th = 64'd158464142;
      7'd42: th = 64'd251156947;
      7'd43: th = 64'd398067267;
      7'd44: th = 64'd630907108;
      7'd45: th = 64'd999936756;
      7'd46: th = 64'd1584813573;
      7'd47: th = 64'd2511786196;
      7'd48: th = 64'd3980945516;
      7'd49: th = 64'd6309414581;
      7'd50: th = 64'd9999800001;
      7'd51: th = 64'd15848680141;
      7'd52: th = 64'd25118547338;
      7'd53: th = 64'd39810318004;
      7'd54: th = 64'd63095232072;
      7'd55: th = 64'd99999367546;
      7'd56: th = 64'd158488523033;
      7'd57: th = 64'd251187640778;
      7'd58: th = 64'd398105908640;
      7'd59: th = 64'd630955755825;
      7'd60: th = 64'd999998000001;
      7'd61: th = 64'd1584890674612;
      7'd62: th = 64'd2511883261725;
      7'd63: th = 64'd3981067715012;
      7'd64: th = 64'd6309568421031;
      7'd65: th = 64'd9999993675446;
      7'd66: th = 64'd15848923962469;
      7'd67: th = 64'd25118854291353;
      7'd68: th = 64'd39810704436204;
      7'd69: th = 64'd63095718561456;
      7'd70: th = 64'd99999980000001;
      7'd71: th = 64'd158489294067605;
      7'd72: th = 64'd251188611453096;
      7'd73: th = 64'd398107130648252;
      7'd74: th = 64'd630957294242466;
      7'd75: th = 64'd999999936754448;
      7'd76: th = 64'd1584893112839681;
      7'd77: th = 64'd2511886331272135;
      7'd78: th = 64'd3981071579343505;
      7'd79: th = 64'd6309573285936287;
      7'd80: th = 64'd9999999800000001;
      7'd81: th = 64'd15848931672826054;
      7'd82: th = 64'd25118863998117164;
      7'd83: th = 64'd39810716656297264;
      7'd84: th = 64'd63095733945642040;
      7'd85: th = 64'd99999999367544469;
      7'd86: th = 64'd158489318449897009;
      7'd87: th = 64'd251188642148583545;
      7'd88: th = 64'd398107169291582563;
      7'd89: th = 64'd630957342891536781;
      7'd90: th = 64'd999999998000000001;
      7'd91: th = 64'd1584893189943262663;
      7'd92: th = 64'd2511886428339793728;
      7'd93: th = 64'd3981071701544447879;
      7'd94: th = 64'd6309573439778159633;
      default: th = '1;
    endcase
    return th;
  endfunction

  // One decimal digit: how many whole multiples of scale fit in v (v < 10*scale)
  function automatic logic [DIGIT_W-1:0] spf_digit(input logic [BCD_W-1:0] v,
                                                   input logic [BCD_W-1:0] scale);
    logic [DIGIT_W-1:0] q;
    q = '0;
    for (int k = 1; k <= DIGIT_MAX; k++) begin
      if (v >= BCD_W'(k) * scale) q = DIGIT_W'(k);
    end
    return q;
  endfunction

  // Four digits {thousands, hundreds, tens, units} of a value below 10000
  function automatic logic [4*DIGIT_W-1:0] spf_bcd4(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0]   rem;
    logic [DIGIT_W-1:0] dt;
    logic [DIGIT_W-1:0] dh;
    logic [DIGIT_W-1:0] dn;
    rem = v;
    dt  = spf_digit(rem, BCD_W'(1000));
    rem = rem - BCD_W'(dt) * BCD_W'(1000);
    dh  = spf_digit(rem, BCD_W'(100));
    rem = rem - BCD_W'(dh) * BCD_W'(100);
    dn  = spf_digit(rem, BCD_W'(10));
    rem = rem - BCD_W'(dn) * BCD_W'(10);
    return {dt, dh, dn, DIGIT_W'(rem)};
  endfunction

endpackage

`default_nettype wire

FILE: sv/spf_front.sv
`default_nettype none

module spf_front import spf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // [31:0] bin_real, [63:32] bin_imag
  input  wire logic                 in_tlast,   // frame_end
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output spf_item_t                 push_item
);

  logic [CNT_W-1:0] bin_cnt_r;
  logic [CNT_W-1:0] bin_cnt_nxt;
  logic [MAG_W-1:0] re_raw;
  logic [MAG_W-1:0] im_raw;
  logic             accept;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  // Magnitudes of the two's complement parts; the most negative value maps to 2^31
  assign re_raw = in_tdata[MAG_W-1:0];
  assign im_raw = in_tdata[IN_DATA_W-1:MAG_W];

  always_comb begin
    push_item.mag_re       = re_raw[MAG_W-1] ? (~re_raw + MAG_W'(1)) : re_raw;
    push_item.mag_im       = im_raw[MAG_W-1] ? (~im_raw + MAG_W'(1)) : im_raw;
    push_item.tag.idx      = IDX_W'(bin_cnt_r);
    push_item.tag.in_range = (bin_cnt_r >= CNT_W'(RANGE_LO)) &&
                             (bin_cnt_r <= CNT_W'(RANGE_HI));
    push_item.tag.last     = in_tlast;
  end

  // Bin counter: saturates at the transform length, clears after the last bin
  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    if (accept) begin
      if (in_tlast) begin
        bin_cnt_nxt = '0;
      end else if (bin_cnt_r < CNT_W'(FFT_LEN)) begin
        bin_cnt_nxt = bin_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
    end else begin
      bin_cnt_r <= bin_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/spf_queue.sv
`default_nettype none

module spf_queue import spf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire spf_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop,
  output spf_item_t      pop_item
);

  spf_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && do_push && !do_pop |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

FILE: sv/spf_back.sv
`default_nettype none

module spf_back import spf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire spf_item_t             q_item,
  input  wire logic [RATE_W-1:0]     rate,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic adv;

  // Squaring stage
  logic             sq_v_r;
  logic [POW_W-1:0] sq_re_r;
  logic [POW_W-1:0] sq_im_r;
  spf_tag_t         sq_tag_r;

  // Level search pipeline; index 0 holds the summed power
  logic             srch_v_r   [SEARCH_STEPS+1];
  logic [POW_W-1:0] srch_pow_r [SEARCH_STEPS+1];
  logic [LVL_W-1:0] srch_lvl_r [SEARCH_STEPS+1];
  spf_tag_t         srch_tag_r [SEARCH_STEPS+1];

  // Running best and frame result
  logic             best_valid_r;
  logic [LVL_W-1:0] best_level_r;
  logic [IDX_W-1:0] best_bin_r;
  logic             cur_v;
  logic [LVL_W-1:0] cur_lvl;
  spf_tag_t         cur_tag;
  logic             upd;
  logic [IDX_W-1:0] sel_bin;
  logic [LVL_W-1:0] sel_lvl;
  logic             res_v_r;
  logic [IDX_W-1:0] res_bin_r;
  logic [LVL_W-1:0] res_lvl_r;

  // Frequency product
  logic              prod_v_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  prod_bin_r;
  logic [LVL_W-1:0]  prod_lvl_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [FREQ_FULL_W-1:0] freq_full;
  logic [4*DIGIT_W-1:0]   digits;

  // Whole back pipeline moves when the output register can take a beat
  assign adv        = !out_valid_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Squares of both magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (adv) begin
      sq_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_re_r  <= q_item.mag_re * q_item.mag_re;
      sq_im_r  <= q_item.mag_im * q_item.mag_im;
      sq_tag_r <= q_item.tag;
    end
  end

  // Power sum enters the search with level zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_v_r[0] <= 1'b0;
    end else if (adv) begin
      srch_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srch_pow_r[0] <= sq_re_r + sq_im_r;
      srch_lvl_r[0] <= '0;
      srch_tag_r[0] <= sq_tag_r;
    end
  end

  // Binary search for the highest level whose threshold the power reaches,
  // one level bit per stage, most significant first
  for (genvar k = 0; k < SEARCH_STEPS; k++) begin : g_srch
    localparam int B = SEARCH_STEPS - 1 - k;
    logic [LVL_W-1:0] cand;
    logic             take;

    always_comb begin
      cand = srch_lvl_r[k] | (LVL_W'(1) << B);
      take = (cand <= LVL_W'(LEVEL_STEPS)) && (srch_pow_r[k] >= spf_level_th(cand));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        srch_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        srch_v_r[k+1] <= srch_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srch_pow_r[k+1] <= srch_pow_r[k];
        srch_lvl_r[k+1] <= take ? cand : srch_lvl_r[k];
        srch_tag_r[k+1] <= srch_tag_r[k];
      end
    end
  end

  // Running best: first bin with a strictly higher level wins
  assign cur_v   = srch_v_r[SEARCH_STEPS];
  assign cur_lvl = srch_lvl_r[SEARCH_STEPS];
  assign cur_tag = srch_tag_r[SEARCH_STEPS];

  always_comb begin
    upd     = cur_v && cur_tag.in_range && (!best_valid_r || (cur_lvl > best_level_r));
    sel_bin = upd ? cur_tag.idx : best_bin_r;
    sel_lvl = upd ? cur_lvl : best_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_level_r <= '0;
      best_bin_r   <= '0;
      res_v_r      <= 1'b0;
    end else if (adv) begin
      res_v_r <= cur_v && cur_tag.last;
      if (cur_v && cur_tag.last) begin
        best_valid_r <= 1'b0;
        best_level_r <= '0;
        best_bin_r   <= '0;
      end else if (upd) begin
        best_valid_r <= 1'b1;
        best_level_r <= cur_lvl;
        best_bin_r   <= cur_tag.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_bin_r <= sel_bin;
      res_lvl_r <= sel_lvl;
    end
  end

  // Peak bin times sample rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (adv) begin
      prod_v_r <= res_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= res_bin_r * rate;
      prod_bin_r <= res_bin_r;
      prod_lvl_r <= res_lvl_r;
    end
  end

  // Divide by the transform length and split into saturating decimal digits
  assign freq_full = prod_r[PROD_W-1:FFT_LOG2];

  always_comb begin
    if (freq_full >= FREQ_FULL_W'(DIGIT_CAP)) begin
      digits = {4{DIGIT_W'(DIGIT_MAX)}};
    end else begin
      digits = spf_bcd4(BCD_W'(freq_full));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= OUT_DATA_W'({digits[DIGIT_W-1:0],               // units
                                 digits[2*DIGIT_W-1:DIGIT_W],       // tens
                                 digits[3*DIGIT_W-1:2*DIGIT_W],     // hundreds
                                 digits[4*DIGIT_W-1:3*DIGIT_W],     // thousands
                                 FREQ_W'(freq_full),
                                 prod_lvl_r,
                                 PEAK_BIN_W'(prod_bin_r)});
    end
  end

`ifndef SYNTH
  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !best_valid_r |-> (best_level_r == '0) && (best_bin_r == '0))
    else $error("running best not clear while no candidate held");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[OUT_DT_LSB +: DIGIT_W] <= DIGIT_W'(DIGIT_MAX)) &&
                    (out_data_r[OUT_DH_LSB +: DIGIT_W] <= DIGIT_W'(DIGIT_MAX)) &&
                    (out_data_r[OUT_DN_LSB +: DIGIT_W] <= DIGIT_W'(DIGIT_MAX)) &&
                    (out_data_r[OUT_DU_LSB +: DIGIT_W] <= DIGIT_W'(DIGIT_MAX)))
    else $error("decimal digit out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/spectral_peak_frequency_finder.sv
`default_nettype none

// Spectral peak finder. Takes the complex bins of one transform frame, one bin
// per input beat with tlast on the last bin, and returns one result beat per
// frame: the first bin in 1 .. N/2-2 with the highest whole-decibel level, that
// level, the frequency bin*rate/N truncated, and its four decimal digits
// (all nines from 9999 Hz up). While the queue has room a bin is taken every
// cycle; the squaring multipliers, the seven-stage threshold search and the
// frequency multiplier are all pipelined, so throughput is then one bin per
// clock. The result beat follows the last bin through the four-entry input
// queue and the back pipeline. An output stall holds the back pipeline while
// the queue keeps taking bins until it fills. The sample rate register may be
// written whenever no frame is in flight; there is no start-up clearing pass.

module spectral_peak_frequency_finder import spf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] bin_real, [63:32] bin_imag
  input  wire logic                  in_tlast,   // frame_end
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [8:0] peak_bin, [15:9] peak_level_db,
                                                 // [34:16] peak_freq_hz,
                                                 // [38:35] digit_thousands,
                                                 // [42:39] digit_hundreds,
                                                 // [46:43] digit_tens,
                                                 // [50:47] digit_units, [55:51] zero
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RATE_W-1:0]     cfg_data    // sample_rate_hz
);

  logic              rate_we;
  logic [RATE_W-1:0] sample_rate_r;
  logic              push_valid;
  logic              push_ready;
  spf_item_t         push_item;
  logic              q_valid;
  logic              q_pop;
  spf_item_t         q_item;

  // Sample rate register
  assign cfg_ready = 1'b1;
  assign rate_we   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= RATE_W'(RATE_RESET);
    end else if (rate_we) begin
      sample_rate_r <= cfg_data;
    end
  end

  spf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  spf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  spf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .rate       (sample_rate_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
